>>> rtl/qet_pkg.sv
// ----------------------------------------------------------------------------
// qet_pkg
// Types, character codes and result helpers for the quoted escape tokenizer.
// ----------------------------------------------------------------------------
package qet_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_LINE_END  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ESCAPE = 2'd1,
        ST_STRING = 2'd2
    } status_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        status_t    status;
        logic       last;
    } result_t;

    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_T      = 8'h74;

    function automatic result_t make_result(kind_t k, logic [7:0] b, status_t s);
        result_t r;
        r.kind     = k;
        r.out_byte = b;
        r.status   = s;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] decode_escape(logic [7:0] c);
        logic [7:0] d;
        case (c)
            CH_N:    d = CH_LF;
            CH_R:    d = CH_CR;
            CH_ZERO: d = 8'h00;
            CH_T:    d = CH_TAB;
            default: d = c;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/qet_in_if.sv
// ----------------------------------------------------------------------------
// qet_in_if
// Command line byte channel: valid/ready with one character request.
// ----------------------------------------------------------------------------
interface qet_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] byte_in;
    logic       line_end;

    modport source (output valid, output has_byte, output byte_in, output line_end,
                    input ready);
    modport sink   (input valid, input has_byte, input byte_in, input line_end,
                    output ready);
endinterface

>>> rtl/qet_out_if.sv
// ----------------------------------------------------------------------------
// qet_out_if
// Token result channel: valid/ready with one decoded result request.
// ----------------------------------------------------------------------------
interface qet_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output kind, output out_byte, output status,
                    output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input status,
                    input last, output ready);
endinterface

>>> rtl/quoted_escape_tokenizer.sv
// The first result of a request is valid in the cycle after the request is taken.
// One request per cycle while each gives at most one result and tok.ready is high; a request
//   that gives k results (k up to 3) holds the result slots until all k are taken.
// The result slot bank (three registers and a count) sets the rate.
// Reset (async, active low) clears the escape, quote and token flags and the slot count.
// ----------------------------------------------------------------------------
// quoted_escape_tokenizer
// Streams decoded token bytes, token ends and line ends from a command line.
// ----------------------------------------------------------------------------
module quoted_escape_tokenizer (
    input  logic         clk,
    input  logic         rst_n,
    qet_in_if.sink       cmd,
    qet_out_if.source    tok
);

    localparam int unsigned CntW = $clog2(qet_pkg::MAX_RESULTS + 1);

    logic esc_reg, quo_reg, tok_reg;
    logic esc_next, quo_next, tok_next;

    qet_pkg::result_t slot_reg [qet_pkg::MAX_RESULTS];
    qet_pkg::result_t res_next [qet_pkg::MAX_RESULTS];
    logic [CntW-1:0]  cnt_reg;
    logic [CntW-1:0]  n_next;

    logic accept, pop;
    qet_pkg::status_t st;

    assign tok.valid    = (cnt_reg != '0);
    assign tok.kind     = slot_reg[0].kind;
    assign tok.out_byte = slot_reg[0].out_byte;
    assign tok.status   = slot_reg[0].status;
    assign tok.last     = slot_reg[0].last;

    assign pop       = tok.valid & tok.ready;
    assign cmd.ready = (cnt_reg == '0) || ((cnt_reg == CntW'(1)) && tok.ready);
    assign accept    = cmd.valid & cmd.ready;

    // decode one request into its result list and next flag state
    always_comb
    begin
        esc_next = esc_reg;
        quo_next = quo_reg;
        tok_next = tok_reg;
        n_next   = '0;
        st       = qet_pkg::ST_OK;
        for (int i = 0; i < qet_pkg::MAX_RESULTS; i++)
        begin
            res_next[i] = qet_pkg::make_result(qet_pkg::KIND_BYTE, 8'h00, qet_pkg::ST_OK);
        end

        if (cmd.has_byte)
        begin
            if (esc_reg)
            begin
                res_next[0] = qet_pkg::make_result(qet_pkg::KIND_BYTE,
                                  qet_pkg::decode_escape(cmd.byte_in), qet_pkg::ST_OK);
                n_next   = CntW'(1);
                tok_next = 1'b1;
                esc_next = 1'b0;
            end
            else if (cmd.byte_in == qet_pkg::CH_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (quo_reg)
            begin
                if (cmd.byte_in == qet_pkg::CH_QUOTE)
                begin
                    // closing quote always ends a token, empty or not
                    res_next[0] = qet_pkg::make_result(qet_pkg::KIND_TOKEN_END, 8'h00,
                                                       qet_pkg::ST_OK);
                    n_next   = CntW'(1);
                    tok_next = 1'b0;
                    quo_next = 1'b0;
                end
                else
                begin
                    res_next[0] = qet_pkg::make_result(qet_pkg::KIND_BYTE, cmd.byte_in,
                                                       qet_pkg::ST_OK);
                    n_next   = CntW'(1);
                    tok_next = 1'b1;
                end
            end
            else if (cmd.byte_in == qet_pkg::CH_QUOTE ||
                     cmd.byte_in inside {qet_pkg::CH_SPACE, qet_pkg::CH_TAB,
                                         qet_pkg::CH_LF, qet_pkg::CH_CR})
            begin
                if (tok_reg)
                begin
                    res_next[0] = qet_pkg::make_result(qet_pkg::KIND_TOKEN_END, 8'h00,
                                                       qet_pkg::ST_OK);
                    n_next = CntW'(1);
                end
                tok_next = 1'b0;
                if (cmd.byte_in == qet_pkg::CH_QUOTE)
                begin
                    quo_next = 1'b1;
                end
            end
            else
            begin
                res_next[0] = qet_pkg::make_result(qet_pkg::KIND_BYTE, cmd.byte_in,
                                                   qet_pkg::ST_OK);
                n_next   = CntW'(1);
                tok_next = 1'b1;
            end
        end

        if (cmd.line_end)
        begin
            if (esc_next)
            begin
                st = qet_pkg::ST_ESCAPE;
            end
            else if (quo_next)
            begin
                st = qet_pkg::ST_STRING;
            end
            // a void partial token gets no token end
            if (st == qet_pkg::ST_OK && tok_next)
            begin
                res_next[n_next[1:0]] = qet_pkg::make_result(qet_pkg::KIND_TOKEN_END,
                                                             8'h00, qet_pkg::ST_OK);
                n_next = n_next + CntW'(1);
            end
            res_next[n_next[1:0]] = qet_pkg::make_result(qet_pkg::KIND_LINE_END, 8'h00, st);
            n_next   = n_next + CntW'(1);
            esc_next = 1'b0;
            quo_next = 1'b0;
            tok_next = 1'b0;
        end

        if (n_next != '0)
        begin
            res_next[2'(n_next - CntW'(1))].last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= 1'b0;
            quo_reg <= 1'b0;
            tok_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                esc_reg <= esc_next;
                quo_reg <= quo_next;
                tok_reg <= tok_next;
                cnt_reg <= n_next;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - CntW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < qet_pkg::MAX_RESULTS; i++)
            begin
                slot_reg[i] <= res_next[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < qet_pkg::MAX_RESULTS - 1; i++)
            begin
                slot_reg[i] <= slot_reg[i+1];
            end
        end
    end

endmodule

>>> test/quoted_escape_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_escape_tokenizer_tb
// Drives command line bytes into the tokenizer and checks every streamed
// token byte, token end and line end against a cycle-free software predictor.
// ----------------------------------------------------------------------------
module quoted_escape_tokenizer_tb;

    typedef struct {
        bit         has_byte;
        logic [7:0] byte_in;
        bit         line_end;
        int         gap;
        bit         drain;
    } cmd_item_t;

    logic clk;
    logic rst_n;

    qet_in_if  cmd_if ();
    qet_out_if tok_if ();

    quoted_escape_tokenizer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_if),
        .tok   (tok_if)
    );

    cmd_item_t        pend_q[$];
    qet_pkg::result_t tok_exp_q[$];
    logic [7:0]       line_q[$];

    cmd_item_t cur;
    bit        have_item;
    int        tx_wait;
    bit        tx_calm;
    int        rx_hold;
    bit        rx_calm;
    int        rx_seen;
    int        fails;
    int        req_count;

    // predictor state
    bit esc_pend;
    bit in_quote;
    bit tok_open;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic predict_tokens(input cmd_item_t it);
        qet_pkg::result_t res [3];
        int               n;
        logic [7:0]       d;
        qet_pkg::status_t st;
        n = 0;
        if (it.has_byte)
        begin
            if (esc_pend)
            begin
                case (it.byte_in)
                    qet_pkg::CH_N:    d = qet_pkg::CH_LF;
                    qet_pkg::CH_R:    d = qet_pkg::CH_CR;
                    qet_pkg::CH_ZERO: d = 8'h00;
                    qet_pkg::CH_T:    d = qet_pkg::CH_TAB;
                    default:          d = it.byte_in;
                endcase
                res[n] = '{qet_pkg::KIND_BYTE, d, qet_pkg::ST_OK, 1'b0};
                n++;
                tok_open = 1'b1;
                esc_pend = 1'b0;
            end
            else if (in_quote)
            begin
                if (it.byte_in == qet_pkg::CH_QUOTE)
                begin
                    res[n] = '{qet_pkg::KIND_TOKEN_END, 8'h00, qet_pkg::ST_OK, 1'b0};
                    n++;
                    tok_open = 1'b0;
                    in_quote = 1'b0;
                end
                else if (it.byte_in == qet_pkg::CH_BSLASH)
                begin
                    esc_pend = 1'b1;
                end
                else
                begin
                    res[n] = '{qet_pkg::KIND_BYTE, it.byte_in, qet_pkg::ST_OK, 1'b0};
                    n++;
                    tok_open = 1'b1;
                end
            end
            else
            begin
                if (it.byte_in == qet_pkg::CH_QUOTE)
                begin
                    if (tok_open)
                    begin
                        res[n] = '{qet_pkg::KIND_TOKEN_END, 8'h00, qet_pkg::ST_OK, 1'b0};
                        n++;
                    end
                    tok_open = 1'b0;
                    in_quote = 1'b1;
                end
                else if (it.byte_in == qet_pkg::CH_BSLASH)
                begin
                    esc_pend = 1'b1;
                end
                else if (it.byte_in == qet_pkg::CH_SPACE || it.byte_in == qet_pkg::CH_TAB ||
                         it.byte_in == qet_pkg::CH_LF || it.byte_in == qet_pkg::CH_CR)
                begin
                    if (tok_open)
                    begin
                        res[n] = '{qet_pkg::KIND_TOKEN_END, 8'h00, qet_pkg::ST_OK, 1'b0};
                        n++;
                    end
                    tok_open = 1'b0;
                end
                else
                begin
                    res[n] = '{qet_pkg::KIND_BYTE, it.byte_in, qet_pkg::ST_OK, 1'b0};
                    n++;
                    tok_open = 1'b1;
                end
            end
        end
        if (it.line_end)
        begin
            if (esc_pend)
                st = qet_pkg::ST_ESCAPE;
            else if (in_quote)
                st = qet_pkg::ST_STRING;
            else
                st = qet_pkg::ST_OK;
            // a broken token is void, so only an ok line closes it
            if (st == qet_pkg::ST_OK && tok_open)
            begin
                res[n] = '{qet_pkg::KIND_TOKEN_END, 8'h00, qet_pkg::ST_OK, 1'b0};
                n++;
            end
            res[n] = '{qet_pkg::KIND_LINE_END, 8'h00, st, 1'b0};
            n++;
            esc_pend = 1'b0;
            in_quote = 1'b0;
            tok_open = 1'b0;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                res[i].last = 1'b1;
            tok_exp_q.push_back(res[i]);
        end
    endtask

    task automatic add_item(input bit has, input logic [7:0] b, input bit endl,
                            input bit drain);
        cmd_item_t it;
        it.has_byte = has;
        it.byte_in  = b;
        it.line_end = endl;
        it.gap      = tx_calm ? 0 : $urandom_range(0, 16);
        it.drain    = drain;
        pend_q.push_back(it);
        if (has || endl)
            req_count++;
    endtask

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] esc_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = qet_pkg::CH_N;
            1:       c = qet_pkg::CH_R;
            2:       c = qet_pkg::CH_ZERO;
            3:       c = qet_pkg::CH_T;
            4:       c = qet_pkg::CH_QUOTE;
            5:       c = qet_pkg::CH_BSLASH;
            6:       c = 8'($urandom_range(0, 255));
            default: c = letter();
        endcase
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = qet_pkg::CH_SPACE;
            1:       c = qet_pkg::CH_TAB;
            2:       c = qet_pkg::CH_LF;
            default: c = qet_pkg::CH_CR;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0:       c = qet_pkg::CH_QUOTE;
            1:       c = qet_pkg::CH_BSLASH;
            2:       c = sep_char();
            3:       c = esc_char();
            4, 5, 6: c = letter();
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    task automatic add_word();
        repeat ($urandom_range(1, 4))
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                line_q.push_back(qet_pkg::CH_BSLASH);
                line_q.push_back(esc_char());
            end
            else
            begin
                line_q.push_back(letter());
            end
        end
    endtask

    task automatic add_quoted();
        line_q.push_back(qet_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 3))
                0: line_q.push_back(sep_char());
                1:
                begin
                    line_q.push_back(qet_pkg::CH_BSLASH);
                    line_q.push_back(esc_char());
                end
                default: line_q.push_back(letter());
            endcase
        end
        line_q.push_back(qet_pkg::CH_QUOTE);
    endtask

    task automatic add_sep();
        repeat ($urandom_range(1, 2)) line_q.push_back(sep_char());
    endtask

    task automatic flush_line(input bit end_item, input bit drain);
        int n;
        n = line_q.size();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                add_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            add_item(1'b1, line_q[i], (i == n - 1) && !end_item, drain && i == 0);
        end
        if (end_item || n == 0)
            add_item(1'b0, 8'($urandom_range(0, 255)), 1'b1, drain && n == 0);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_if.valid && cmd_if.ready)
            begin
                predict_tokens(cur);
                have_item = 1'b0;
            end
            if (!(cmd_if.valid && !cmd_if.ready))
            begin
                if (!have_item && pend_q.size() != 0)
                begin
                    cur       = pend_q.pop_front();
                    have_item = 1'b1;
                    tx_wait   = cur.gap;
                end
                if (have_item && tx_wait == 0 && (!cur.drain || tok_exp_q.size() == 0))
                begin
                    cmd_if.valid    <= 1'b1;
                    cmd_if.has_byte <= cur.has_byte;
                    cmd_if.byte_in  <= cur.byte_in;
                    cmd_if.line_end <= cur.line_end;
                end
                else
                begin
                    if (have_item && tx_wait > 0)
                        tx_wait--;
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tok_if.valid && tok_if.ready)
            begin
                if (tok_exp_q.size() == 0)
                begin
                    $display("%0t: result with none expected: kind %0d byte %h status %0d",
                             $time, tok_if.kind, tok_if.out_byte, tok_if.status,
                             " last %0d", tok_if.last);
                    fails++;
                end
                else
                begin
                    qet_pkg::result_t e;
                    e = tok_exp_q.pop_front();
                    if (tok_if.kind !== e.kind)
                    begin
                        $display("%0t: kind expected %0d actual %0d",
                                 $time, e.kind, tok_if.kind);
                        fails++;
                    end
                    if (tok_if.out_byte !== e.out_byte)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, e.out_byte, tok_if.out_byte);
                        fails++;
                    end
                    if (tok_if.status !== e.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, e.status, tok_if.status);
                        fails++;
                    end
                    if (tok_if.last !== e.last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, e.last, tok_if.last);
                        fails++;
                    end
                end
                rx_seen++;
                if (rx_seen % 40 == 0)
                    rx_calm = ($urandom_range(0, 2) == 0);
                rx_hold = rx_calm ? 0 : $urandom_range(0, 16);
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
            end
            tok_if.ready <= (rx_hold == 0);
        end
    end

    initial
    begin
        int lkind;
        int parts;
        rst_n           = 1'b0;
        cmd_if.valid    = 1'b0;
        cmd_if.has_byte = 1'b0;
        cmd_if.byte_in  = 8'h00;
        cmd_if.line_end = 1'b0;
        tok_if.ready    = 1'b0;
        have_item       = 1'b0;
        tx_wait         = 0;
        tx_calm         = 1'b0;
        rx_hold         = 0;
        rx_calm         = 1'b0;
        rx_seen         = 0;
        fails           = 0;
        req_count       = 0;
        esc_pend        = 1'b0;
        in_quote        = 1'b0;
        tok_open        = 1'b0;

        // directed: empty item, plain bytes and field extremes
        add_item(1'b0, 8'h00, 1'b0, 1'b0);
        add_item(1'b1, "a", 1'b0, 1'b0);
        add_item(1'b1, 8'h00, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_SPACE, 1'b0, 1'b0);
        // every decoded escape, then pass-through ones
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_N, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_R, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_ZERO, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_T, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_QUOTE, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b0, 1'b0);
        add_item(1'b1, 8'hFF, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_TAB, 1'b0, 1'b0);
        // quote ends an open token, quoted space, then an empty string
        add_item(1'b1, "c", 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_QUOTE, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_SPACE, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_QUOTE, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_QUOTE, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_QUOTE, 1'b0, 1'b0);
        // byte with line end: byte, token end, line end; sent after a full drain
        add_item(1'b1, "e", 1'b1, 1'b1);
        // escape left open inside a string: escape status wins
        add_item(1'b1, qet_pkg::CH_QUOTE, 1'b0, 1'b0);
        add_item(1'b1, qet_pkg::CH_BSLASH, 1'b1, 1'b0);
        // string left open
        add_item(1'b1, qet_pkg::CH_QUOTE, 1'b0, 1'b0);
        add_item(1'b1, "a", 1'b0, 1'b0);
        add_item(1'b0, 8'hA5, 1'b1, 1'b0);

        // random lines: mostly well formed, some cut short, some pure noise
        while (req_count < 200)
        begin
            line_q.delete();
            tx_calm = ($urandom_range(0, 3) == 0);
            lkind   = $urandom_range(0, 9);
            if (lkind < 7)
            begin
                parts = $urandom_range(1, 4);
                if ($urandom_range(0, 3) == 0)
                    add_sep();
                for (int p = 0; p < parts; p++)
                begin
                    if ($urandom_range(0, 2) == 0)
                        add_quoted();
                    else
                        add_word();
                    if (p < parts - 1 || $urandom_range(0, 3) == 0)
                        add_sep();
                end
                if (lkind == 6)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        line_q.push_back(qet_pkg::CH_BSLASH);
                    end
                    else
                    begin
                        line_q.push_back(qet_pkg::CH_QUOTE);
                        add_word();
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 10)) line_q.push_back(any_char());
            end
            flush_line(1'($urandom_range(0, 1)), $urandom_range(0, 14) == 0);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || have_item || cmd_if.valid) @(posedge clk);
        while (tok_exp_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
